/* rtl/core/sblc_pkg.sv */
`timescale 1ns / 1ps
// Package for the size-budget LRU cache: widths, codes, FSM and command types.
// No dependencies.
package sblc_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int SLOT_W      = $clog2(MAX_ENTRIES);
	localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
	localparam int ID_W        = 16;
	localparam int PX_W        = 22;
	localparam int BPP_W       = 3;
	localparam int SIZE_W      = 24;
	localparam int BYTES_W     = 27;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [BYTES_W-1:0] CAP_RESET = BYTES_W'(4194304);
	localparam logic [BPP_W-1:0]   BPP_RESET = BPP_W'(2);
	localparam logic [BPP_W-1:0]   BPP_MAX   = BPP_W'(4);

	localparam logic [1:0] REG_CAPACITY = 2'd0;
	localparam logic [1:0] REG_BPP      = 2'd1;
	localparam logic [1:0] REG_KIND     = 2'd2;

	localparam logic [2:0] STS_HIT      = 3'd0;
	localparam logic [2:0] STS_LOADED   = 3'd1;
	localparam logic [2:0] STS_EVICTED  = 3'd2;
	localparam logic [2:0] STS_DROPPED  = 3'd3;
	localparam logic [2:0] STS_IGNORED  = 3'd4;
	localparam logic [2:0] STS_TOOLARGE = 3'd5;
	localparam logic [2:0] STS_CLEARED  = 3'd6;

	localparam logic [1:0] REQ_CLEAR = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MISS,
		ST_EVICT,
		ST_CLEAR
	} sblc_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_HIT,
		OP_REFRESH,
		OP_IGNORE,
		OP_TOOBIG,
		OP_EVICT,
		OP_INSERT,
		OP_CLEAR,
		OP_CLEAR_EMPTY
	} sblc_op_t;

	typedef struct packed {
		sblc_op_t op;
	} sblc_cmd_t;

	typedef struct packed {
		logic is_clear;
		logic kind_ok;
		logic hit;
		logic refresh_drop;
		logic too_large;
		logic need_evict;
		logic last_entry;
		logic empty;
	} sblc_stat_t;

endpackage

/* rtl/core/sblc_ctrl.sv */
`timescale 1ns / 1ps
// Controller FSM of the size-budget LRU cache: sequences lookup, eviction,
// insertion and clear. Depends on sblc_pkg.
module sblc_ctrl import sblc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  sblc_stat_t stat,
	output sblc_cmd_t  cmd,
	output logic       busy
);

	sblc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (stat.is_clear) state_d = ST_CLEAR;
				else if (!stat.kind_ok) state_d = ST_IDLE;
				else if (stat.hit && stat.refresh_drop) state_d = ST_MISS;
				else if (stat.hit) state_d = ST_IDLE;
				else state_d = ST_MISS;
			end
			ST_MISS: begin
				state_d = stat.too_large ? ST_IDLE : ST_EVICT;
			end
			ST_EVICT: begin
				if (!stat.need_evict) state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				if (stat.empty || stat.last_entry) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_NONE;
		busy   = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (start) cmd.op = OP_LATCH;
			end
			ST_DECODE: begin
				if (stat.is_clear) cmd.op = OP_NONE;
				else if (!stat.kind_ok) cmd.op = OP_IGNORE;
				else if (stat.hit && stat.refresh_drop) cmd.op = OP_REFRESH;
				else if (stat.hit) cmd.op = OP_HIT;
			end
			ST_MISS: begin
				if (stat.too_large) cmd.op = OP_TOOBIG;
			end
			ST_EVICT: begin
				cmd.op = stat.need_evict ? OP_EVICT : OP_INSERT;
			end
			ST_CLEAR: begin
				cmd.op = stat.empty ? OP_CLEAR_EMPTY : OP_CLEAR;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

/* rtl/core/sblc_dpath.sv */
`timescale 1ns / 1ps
// Datapath of the size-budget LRU cache: slot table, recency order, totals
// and result register. Depends on sblc_pkg.
module sblc_dpath import sblc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  sblc_cmd_t          cmd,
	output sblc_stat_t         stat,
	input  logic [BYTES_W-1:0] capacity_bytes,
	input  logic [BPP_W-1:0]   bytes_per_pixel,
	input  logic               cache_kind,
	input  logic [1:0]         req_type,
	input  logic [ID_W-1:0]    object_id,
	input  logic [PX_W-1:0]    pixel_count,
	input  logic               refresh,
	output logic               strobe,
	output logic [2:0]         status,
	output logic [ID_W-1:0]    result_id,
	output logic [BYTES_W-1:0] total_bytes,
	output logic [COUNT_W-1:0] entry_count,
	output logic               last
);

	typedef logic [MAX_ENTRIES-1:0][SLOT_W-1:0] ord_arr_t;

	function automatic ord_arr_t f_front(ord_arr_t o, logic [SLOT_W-1:0] p);
		ord_arr_t r;
		r = o;
		for (int j = 0; j < MAX_ENTRIES; j++) begin
			if (j == 0) r[j] = o[p];
			else if (j <= int'(p)) r[j] = o[j-1];
		end
		return r;
	endfunction

	function automatic ord_arr_t f_drop(ord_arr_t o, logic [SLOT_W-1:0] p);
		ord_arr_t r;
		r = o;
		for (int j = 0; j < MAX_ENTRIES - 1; j++) begin
			if (j >= int'(p)) r[j] = o[j+1];
		end
		r[MAX_ENTRIES-1] = o[p];
		return r;
	endfunction

	logic [MAX_ENTRIES-1:0] valid_q, valid_d;
	logic [ID_W-1:0]        key_q   [MAX_ENTRIES];
	logic [SIZE_W-1:0]      bytes_q [MAX_ENTRIES];
	ord_arr_t               ord_q, ord_d;
	logic [BYTES_W-1:0]     res_bytes_q, res_bytes_d;
	logic [COUNT_W-1:0]     count_q, count_d;

	logic [1:0]        req_q;
	logic [ID_W-1:0]   id_q;
	logic              refresh_q;
	logic [SIZE_W-1:0] size_q;
	logic [BPP_W-1:0]  bpp;

	logic [SLOT_W-1:0] hit_slot, hit_pos, drop_pos, drop_slot, ins_slot;
	logic              hit_any;
	logic [BYTES_W:0]  need_sum;

	logic              emit;
	logic [2:0]        emit_sts;
	logic [ID_W-1:0]   emit_id;
	logic              emit_last;
	logic              wr_slot;

	assign bpp = (bytes_per_pixel > BPP_MAX) ? BPP_MAX : bytes_per_pixel;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LATCH) begin
			req_q     <= req_type;
			id_q      <= object_id;
			refresh_q <= refresh;
			size_q    <= SIZE_W'(pixel_count) * SIZE_W'(bpp);
		end
	end

	always_comb begin
		hit_any  = 1'b0;
		hit_slot = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (valid_q[i] && key_q[i] == id_q) begin
				hit_any  = 1'b1;
				hit_slot = SLOT_W'(i);
			end
		end
		hit_pos = '0;
		for (int p = 0; p < MAX_ENTRIES; p++) begin
			if (ord_q[p] == hit_slot) hit_pos = SLOT_W'(p);
		end
	end

	assign need_sum = {1'b0, res_bytes_q} + (BYTES_W+1)'(size_q);

	always_comb begin
		stat.is_clear     = (req_q == REQ_CLEAR);
		stat.kind_ok      = !req_q[1] && (req_q[0] == cache_kind);
		stat.hit          = hit_any;
		stat.refresh_drop = req_q[0] && refresh_q;
		stat.too_large    = ({3'b0, size_q} >= capacity_bytes);
		stat.need_evict   = (count_q != '0 && need_sum >= {1'b0, capacity_bytes})
			|| (count_q >= COUNT_W'(MAX_ENTRIES));
		stat.last_entry   = (count_q == COUNT_W'(1));
		stat.empty        = (count_q == '0);
	end

	always_comb begin
		case (cmd.op)
			OP_REFRESH: drop_pos = hit_pos;
			OP_EVICT:   drop_pos = SLOT_W'(count_q - COUNT_W'(1));
			default:    drop_pos = '0;
		endcase
	end

	assign drop_slot = ord_q[drop_pos];
	assign ins_slot  = ord_q[count_q[SLOT_W-1:0]];

	always_comb begin
		valid_d     = valid_q;
		ord_d       = ord_q;
		res_bytes_d = res_bytes_q;
		count_d     = count_q;
		emit        = 1'b0;
		emit_sts    = STS_HIT;
		emit_id     = id_q;
		emit_last   = 1'b0;
		wr_slot     = 1'b0;
		case (cmd.op)
			OP_HIT: begin
				ord_d     = f_front(ord_q, hit_pos);
				emit      = 1'b1;
				emit_last = 1'b1;
			end
			OP_REFRESH, OP_EVICT, OP_CLEAR: begin
				valid_d[drop_slot] = 1'b0;
				ord_d       = f_drop(ord_q, drop_pos);
				res_bytes_d = res_bytes_q - BYTES_W'(bytes_q[drop_slot]);
				count_d     = count_q - COUNT_W'(1);
				emit        = 1'b1;
				if (cmd.op == OP_REFRESH) begin
					emit_sts = STS_DROPPED;
				end else if (cmd.op == OP_EVICT) begin
					emit_sts = STS_EVICTED;
					emit_id  = key_q[drop_slot];
				end else begin
					emit_sts  = STS_CLEARED;
					emit_id   = key_q[drop_slot];
					emit_last = (count_q == COUNT_W'(1));
				end
			end
			OP_IGNORE: begin
				emit      = 1'b1;
				emit_sts  = STS_IGNORED;
				emit_last = 1'b1;
			end
			OP_TOOBIG: begin
				emit      = 1'b1;
				emit_sts  = STS_TOOLARGE;
				emit_last = 1'b1;
			end
			OP_INSERT: begin
				valid_d[ins_slot] = 1'b1;
				wr_slot     = 1'b1;
				res_bytes_d = need_sum[BYTES_W-1:0];
				count_d     = count_q + COUNT_W'(1);
				ord_d       = f_front(ord_q, count_q[SLOT_W-1:0]);
				emit        = 1'b1;
				emit_sts    = STS_LOADED;
				emit_last   = 1'b1;
			end
			OP_CLEAR_EMPTY: begin
				emit      = 1'b1;
				emit_sts  = STS_CLEARED;
				emit_id   = '0;
				emit_last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			res_bytes_q <= '0;
			count_q     <= '0;
			strobe      <= 1'b0;
			for (int i = 0; i < MAX_ENTRIES; i++) ord_q[i] <= SLOT_W'(i);
		end else begin
			valid_q     <= valid_d;
			ord_q       <= ord_d;
			res_bytes_q <= res_bytes_d;
			count_q     <= count_d;
			strobe      <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_slot) begin
			key_q[ins_slot]   <= id_q;
			bytes_q[ins_slot] <= size_q;
		end
		if (emit) begin
			status      <= emit_sts;
			result_id   <= emit_id;
			total_bytes <= res_bytes_d;
			entry_count <= count_d;
			last        <= emit_last;
		end
	end

endmodule

/* rtl/core/size_budget_lru_cache_unit.sv */
`timescale 1ns / 1ps
// Top level of the size-budget LRU cache: config registers, controller and
// datapath. Depends on sblc_pkg, sblc_ctrl, sblc_dpath.
//
// Usage: present a request with start while busy is low; it is taken at that
// edge and busy rises. Each result appears for one cycle with strobe high;
// last marks the final result of a request, and busy is low by then.
// Results cannot be held off. Configuration goes through the APB port
// (capacity at 0x0, bytes per pixel at 0x4, kind at 0x8) while idle.
// Sequence: acceptance in idle, then a decode step; a hit or ignored access
// gives its result from the decode step. A miss passes a miss step, where a
// too-large object gives its result, then an evict step that evicts as needed
// and then inserts. A clear drops the resident entries one by one, or gives one
// result if empty. Evictions walk the recency order one entry per cycle.
// Reset empties the cache, sets the recency order to identity and loads
// the configuration defaults; no clearing pass is needed.
module size_budget_lru_cache_unit import sblc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic [ID_W-1:0]    object_id,
	input  logic [PX_W-1:0]    pixel_count,
	input  logic               refresh,
	output logic               strobe,
	output logic [2:0]         status,
	output logic [ID_W-1:0]    result_id,
	output logic [BYTES_W-1:0] total_bytes,
	output logic [COUNT_W-1:0] entry_count,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	logic [BYTES_W-1:0] cap_q;
	logic [BPP_W-1:0]   bpp_q;
	logic               kind_q;
	logic               cfg_wr;
	sblc_cmd_t          cmd;
	sblc_stat_t         stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RESET;
			bpp_q  <= BPP_RESET;
			kind_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_CAPACITY: cap_q  <= pwdata[BYTES_W-1:0];
				REG_BPP:      bpp_q  <= pwdata[BPP_W-1:0];
				REG_KIND:     kind_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_CAPACITY: prdata = DATA_W'(cap_q);
			REG_BPP:      prdata = DATA_W'(bpp_q);
			REG_KIND:     prdata = DATA_W'(kind_q);
			default:      prdata = '0;
		endcase
	end

	sblc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	sblc_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.capacity_bytes  (cap_q),
		.bytes_per_pixel (bpp_q),
		.cache_kind      (kind_q),
		.req_type        (req_type),
		.object_id       (object_id),
		.pixel_count     (pixel_count),
		.refresh         (refresh),
		.strobe          (strobe),
		.status          (status),
		.result_id       (result_id),
		.total_bytes     (total_bytes),
		.entry_count     (entry_count),
		.last            (last)
	);

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy) else $error("busy after final result");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("transaction not taken");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> entry_count <= COUNT_W'(MAX_ENTRIES)) else $error("count overflow");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last && status == STS_CLEARED |-> total_bytes == '0 && entry_count == '0)
		else $error("clear left residue");

endmodule
